[rtl/mexp_pkg.sv]
// Package for the modular exponentiation block: types, microcode codes and the control store.
`default_nettype none

package mexp_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);
    localparam int PC_W = 4;

    typedef logic [WIDTH-1:0] word_t;
    typedef logic [PC_W-1:0] pc_t;

    localparam logic [3:0] OP_NOP          = 4'd0;
    localparam logic [3:0] OP_LOAD         = 4'd1;
    localparam logic [3:0] OP_RED_INIT     = 4'd2;
    localparam logic [3:0] OP_RED_STEP     = 4'd3;
    localparam logic [3:0] OP_RED_DONE     = 4'd4;
    localparam logic [3:0] OP_MUL_ACC_INIT = 4'd5;
    localparam logic [3:0] OP_MUL_SQ_INIT  = 4'd6;
    localparam logic [3:0] OP_MUL_STEP     = 4'd7;
    localparam logic [3:0] OP_MUL_ACC_DONE = 4'd8;
    localparam logic [3:0] OP_SQ_DONE      = 4'd9;
    localparam logic [3:0] OP_EMIT         = 4'd10;

    localparam logic [3:0] C_NEXT     = 4'd0;
    localparam logic [3:0] C_ALWAYS   = 4'd1;
    localparam logic [3:0] C_NO_INPUT = 4'd2;
    localparam logic [3:0] C_EARLY    = 4'd3;
    localparam logic [3:0] C_CNT_MORE = 4'd4;
    localparam logic [3:0] C_BIT_CLR  = 4'd5;
    localparam logic [3:0] C_Y_MORE   = 4'd6;
    localparam logic [3:0] C_EXP_MORE = 4'd7;
    localparam logic [3:0] C_OUT_FULL = 4'd8;

    localparam pc_t STEP_WAIT     = 4'd0;
    localparam pc_t STEP_CHECK    = 4'd1;
    localparam pc_t STEP_RED_INIT = 4'd2;
    localparam pc_t STEP_RED      = 4'd3;
    localparam pc_t STEP_RED_DONE = 4'd4;
    localparam pc_t STEP_LOOP     = 4'd5;
    localparam pc_t STEP_MA_INIT  = 4'd6;
    localparam pc_t STEP_MA       = 4'd7;
    localparam pc_t STEP_MA_DONE  = 4'd8;
    localparam pc_t STEP_SQ_INIT  = 4'd9;
    localparam pc_t STEP_SQ       = 4'd10;
    localparam pc_t STEP_SQ_DONE  = 4'd11;
    localparam pc_t STEP_EMIT     = 4'd12;
    localparam pc_t STEP_RETURN   = 4'd13;

    typedef struct packed {
        logic [3:0] op;
        logic [3:0] cond;
        pc_t        target;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic early;
        logic cnt_more;
        logic exp_bit_clr;
        logic y_more;
        logic exp_more;
        logic out_full;
    } status_t;

    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        case (pc)
            STEP_WAIT:     w = '{OP_LOAD,         C_NO_INPUT, STEP_WAIT};
            STEP_CHECK:    w = '{OP_NOP,          C_EARLY,    STEP_EMIT};
            STEP_RED_INIT: w = '{OP_RED_INIT,     C_NEXT,     STEP_WAIT};
            STEP_RED:      w = '{OP_RED_STEP,     C_CNT_MORE, STEP_RED};
            STEP_RED_DONE: w = '{OP_RED_DONE,     C_NEXT,     STEP_WAIT};
            STEP_LOOP:     w = '{OP_NOP,          C_BIT_CLR,  STEP_SQ_INIT};
            STEP_MA_INIT:  w = '{OP_MUL_ACC_INIT, C_NEXT,     STEP_WAIT};
            STEP_MA:       w = '{OP_MUL_STEP,     C_Y_MORE,   STEP_MA};
            STEP_MA_DONE:  w = '{OP_MUL_ACC_DONE, C_NEXT,     STEP_WAIT};
            STEP_SQ_INIT:  w = '{OP_MUL_SQ_INIT,  C_NEXT,     STEP_WAIT};
            STEP_SQ:       w = '{OP_MUL_STEP,     C_Y_MORE,   STEP_SQ};
            STEP_SQ_DONE:  w = '{OP_SQ_DONE,      C_EXP_MORE, STEP_LOOP};
            STEP_EMIT:     w = '{OP_EMIT,         C_OUT_FULL, STEP_EMIT};
            STEP_RETURN:   w = '{OP_NOP,          C_ALWAYS,   STEP_WAIT};
            default:       w = '{OP_NOP,          C_ALWAYS,   STEP_WAIT};
        endcase
        return w;
    endfunction

    // Sum of two residues below m, folded back below m.
    function automatic word_t add_mod(input word_t x, input word_t y, input word_t m);
        logic [WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/mexp_if.sv]
// Valid/ready channel interfaces for the request and result words.
`default_nettype none

interface mexp_in_if
    import mexp_pkg::*;
;
    logic  valid;
    logic  ready;
    word_t base;
    word_t exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if
    import mexp_pkg::*;
;
    logic  valid;
    logic  ready;
    word_t power_mod;
    logic  modulus_error;

    modport source (output valid, output power_mod, output modulus_error, input ready);
    modport sink (input valid, input power_mod, input modulus_error, output ready);
endinterface

`default_nettype wire

[rtl/mexp_seq.sv]
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none

module mexp_seq
    import mexp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire status_t status,
    output ucode_t       ctrl
);

    pc_t  pc_reg;
    pc_t  pc_next;
    logic take;

    assign ctrl = ucode_rom(pc_reg);

    always_comb
    begin
        case (ctrl.cond)
            C_NEXT:     take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_INPUT: take = !status.in_valid;
            C_EARLY:    take = status.early;
            C_CNT_MORE: take = status.cnt_more;
            C_BIT_CLR:  take = status.exp_bit_clr;
            C_Y_MORE:   take = status.y_more;
            C_EXP_MORE: take = status.exp_more;
            C_OUT_FULL: take = status.out_full;
            default:    take = 1'b0;
        endcase
        pc_next = take ? ctrl.target : pc_t'(pc_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_SQ_DONE && !status.exp_more) |=> pc_reg == STEP_EMIT)
        else $error("Last squaring did not lead to the emit step.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_CHECK && status.early) |=> pc_reg == STEP_EMIT)
        else $error("Early result did not lead to the emit step.");

endmodule

`default_nettype wire

[rtl/mexp_datapath.sv]
// Datapath: operand registers, modular add-double unit, reduction unit and result register.
`default_nettype none

module mexp_datapath
    import mexp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire ucode_t ctrl,
    output status_t     status,
    input  wire logic   cfg_we,
    input  wire word_t  cfg_wdata,
    mexp_in_if.sink     req,
    mexp_out_if.source  rsp
);

    word_t            mod_cfg_reg;
    word_t            m_reg, m_next;
    word_t            a_reg, a_next;
    word_t            n_reg, n_next;
    word_t            acc_reg, acc_next;
    word_t            x_reg, x_next;
    word_t            y_reg, y_next;
    word_t            p_reg, p_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             err_reg, err_next;
    logic             out_valid_reg, out_valid_next;
    word_t            res_reg, res_next;
    logic             res_err_reg, res_err_next;
    logic             load_en;
    logic             emit_en;
    logic             out_full;
    logic [WIDTH:0]   red_sum;

    assign out_full = out_valid_reg && !rsp.ready;
    assign load_en = (ctrl.op == OP_LOAD) && req.valid;
    assign emit_en = (ctrl.op == OP_EMIT) && !out_full;
    assign red_sum = {p_reg, x_reg[WIDTH-1]};

    assign req.ready = (ctrl.op == OP_LOAD);
    assign rsp.valid = out_valid_reg;
    assign rsp.power_mod = res_reg;
    assign rsp.modulus_error = res_err_reg;

    assign status.in_valid = req.valid;
    assign status.early = err_reg || (n_reg == '0);
    assign status.cnt_more = (cnt_reg != '0);
    assign status.exp_bit_clr = !n_reg[0];
    assign status.y_more = (y_reg[WIDTH-1:1] != '0);
    assign status.exp_more = (n_reg[WIDTH-1:1] != '0);
    assign status.out_full = out_full;

    always_comb
    begin
        m_next = m_reg;
        a_next = a_reg;
        n_next = n_reg;
        acc_next = acc_reg;
        x_next = x_reg;
        y_next = y_reg;
        p_next = p_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        res_next = res_reg;
        res_err_next = res_err_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        case (ctrl.op)
            OP_LOAD:
            begin
                if (load_en)
                begin
                    m_next = mod_cfg_reg;
                    a_next = req.base;
                    n_next = req.exponent;
                    err_next = (mod_cfg_reg == '0);
                    if (mod_cfg_reg == '0)
                    begin
                        acc_next = '0;
                    end
                    else if (req.exponent == '0)
                    begin
                        acc_next = word_t'(1);
                    end
                    else if (mod_cfg_reg == word_t'(1))
                    begin
                        acc_next = '0;
                    end
                    else
                    begin
                        acc_next = word_t'(1);
                    end
                end
            end
            OP_RED_INIT:
            begin
                x_next = a_reg;
                p_next = '0;
                cnt_next = CNT_W'(WIDTH - 1);
            end
            OP_RED_STEP:
            begin
                if (red_sum >= {1'b0, m_reg})
                begin
                    p_next = word_t'(red_sum - {1'b0, m_reg});
                end
                else
                begin
                    p_next = red_sum[WIDTH-1:0];
                end
                x_next = {x_reg[WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
            end
            OP_RED_DONE:
            begin
                a_next = p_reg;
            end
            OP_MUL_ACC_INIT:
            begin
                x_next = a_reg;
                y_next = acc_reg;
                p_next = '0;
            end
            OP_MUL_SQ_INIT:
            begin
                x_next = a_reg;
                y_next = a_reg;
                p_next = '0;
            end
            OP_MUL_STEP:
            begin
                if (y_reg[0])
                begin
                    p_next = add_mod(p_reg, x_reg, m_reg);
                end
                x_next = add_mod(x_reg, x_reg, m_reg);
                y_next = {1'b0, y_reg[WIDTH-1:1]};
            end
            OP_MUL_ACC_DONE:
            begin
                acc_next = p_reg;
            end
            OP_SQ_DONE:
            begin
                a_next = p_reg;
                n_next = {1'b0, n_reg[WIDTH-1:1]};
            end
            OP_EMIT:
            begin
                if (emit_en)
                begin
                    res_next = acc_reg;
                    res_err_next = err_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_cfg_reg <= word_t'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mod_cfg_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next;
        a_reg <= a_next;
        n_reg <= n_next;
        acc_reg <= acc_next;
        x_reg <= x_next;
        y_reg <= y_next;
        p_reg <= p_next;
        cnt_reg <= cnt_next;
        err_reg <= err_next;
        res_reg <= res_next;
        res_err_reg <= res_err_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_MUL_STEP && !err_reg) |-> (x_reg < m_reg) && (p_reg < m_reg))
        else $error("Multiplier operand left the residue range.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_err_reg) |-> res_reg == '0)
        else $error("Zero modulus gave a nonzero result.");

endmodule

`default_nettype wire

[rtl/modular_exponentiation.sv]
// Top level of the modular exponentiation block: sequencer and datapath.
//
// The request channel (req) carries a word of base and exponent; the result
// channel (rsp) carries power_mod and modulus_error, both valid/ready.
// The modulus register is to be written through cfg_we and cfg_wdata only while
// the block is idle; the block itself does not enforce this. It resets to one.
// The block works on one word at a time under a microcode program.
// The base is first reduced in 32 restoring steps before the exponent loop starts.
// For each exponent bit the loop step and the squaring run, and when the bit is
// set the multiplication runs first, one shift-and-add step per multiplier bit
// on the shared unit. The next word is taken only after the last result is in
// the output register.
// A zero exponent or a zero modulus skips the reduction and the exponent loop
// and goes straight to the emit step.
// The result sits in an output register, so a new request is taken while
// the receiver has not yet taken the last result; when the receiver stalls
// with a second result ready, the program waits at its emit step.
// Reset returns the program to its wait step and empties the output register.
`default_nettype none

module modular_exponentiation
    import mexp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire word_t cfg_wdata,
    mexp_in_if.sink    req,
    mexp_out_if.source rsp
);

    ucode_t  ctrl;
    status_t status;

    mexp_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    mexp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

[tb/sv/modular_exponentiation_tb.sv]
// Testbench for modular_exponentiation: directed table, then random words checked by a predictor.
`default_nettype none

module modular_exponentiation_tb
    import mexp_pkg::*;
;

    localparam int  CLK_HALF = 6;
    localparam int  RESET_CYCLES = 6;
    localparam int  WORDS_PER_PHASE = 25;
    localparam int  RANDOM_PHASES = 10;
    localparam int  SETTLE_CYCLES = 40;
    localparam int  DRAIN_LIMIT = 20000;
    localparam int  MAX_REPORTS = 10;
    localparam time RUN_LIMIT = 36_000_000;

    typedef struct packed {
        word_t power_mod;
        logic  modulus_error;
    } power_result_t;

    typedef struct packed {
        logic  load_modulus;
        word_t modulus;
        word_t base;
        word_t exponent;
        logic  typed;
        word_t power_mod;
        logic  modulus_error;
    } stim_row_t;

    logic  clk;
    logic  rst_n;
    logic  cfg_we;
    word_t cfg_wdata;

    mexp_in_if  req_if ();
    mexp_out_if rsp_if ();

    modular_exponentiation i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    power_result_t pending_results [$];
    word_t         modulus_setting;
    bit            calm_phase;
    int            failures;
    int            words_sent;
    int            results_checked;
    int            error_results;
    int            moduli_written;

    stim_row_t directed_rows [0:20] = '{
        '{1'b0, 32'd0,          32'd5,          32'd0,          1'b1, 32'd1,          1'b0},
        '{1'b0, 32'd0,          32'd7,          32'd3,          1'b1, 32'd0,          1'b0},
        '{1'b1, 32'd0,          32'd3,          32'd5,          1'b1, 32'd0,          1'b1},
        '{1'b0, 32'd0,          32'd0,          32'd0,          1'b1, 32'd0,          1'b1},
        '{1'b0, 32'd0,          32'hFFFFFFFF,   32'hFFFFFFFF,   1'b1, 32'd0,          1'b1},
        '{1'b1, 32'd13,         32'd2,          32'd10,         1'b1, 32'd10,         1'b0},
        '{1'b0, 32'd0,          32'd100,        32'd1,          1'b1, 32'd9,          1'b0},
        '{1'b0, 32'd0,          32'd0,          32'd5,          1'b1, 32'd0,          1'b0},
        '{1'b0, 32'd0,          32'd0,          32'd0,          1'b1, 32'd1,          1'b0},
        '{1'b0, 32'd0,          32'd13,         32'd7,          1'b1, 32'd0,          1'b0},
        '{1'b1, 32'hFFFFFFFF,   32'hFFFFFFFF,   32'hFFFFFFFF,   1'b1, 32'd0,          1'b0},
        '{1'b0, 32'd0,          32'hFFFFFFFE,   32'd2,          1'b1, 32'd1,          1'b0},
        '{1'b0, 32'd0,          32'hFFFFFFFE,   32'hFFFFFFFF,   1'b1, 32'hFFFFFFFE,   1'b0},
        '{1'b0, 32'd0,          32'd2,          32'd32,         1'b1, 32'd1,          1'b0},
        '{1'b1, 32'hFFFFFFFB,   32'h12345678,   32'hFFFFFFFA,   1'b1, 32'd1,          1'b0},
        '{1'b0, 32'd0,          32'hFFFFFFFF,   32'd1,          1'b1, 32'd4,          1'b0},
        '{1'b0, 32'd0,          32'hDEADBEEF,   32'hFFFFFFFF,   1'b0, 32'd0,          1'b0},
        '{1'b1, 32'h80000000,   32'd3,          32'h80000001,   1'b0, 32'd0,          1'b0},
        '{1'b0, 32'd0,          32'hFFFFFFFF,   32'd2,          1'b1, 32'd1,          1'b0},
        '{1'b1, 32'd2,          32'hAAAAAAAB,   32'h55555555,   1'b1, 32'd1,          1'b0},
        '{1'b1, 32'd1,          32'hFFFFFFFF,   32'd1,          1'b1, 32'd0,          1'b0}
    };

    function automatic power_result_t predict_power(input word_t b, input word_t e,
                                                    input word_t m);
        power_result_t r;
        logic [63:0]   acc;
        logic [63:0]   sq;
        logic [63:0]   m64;
        word_t         n;
        r = '0;
        if (m == '0)
        begin
            r.modulus_error = 1'b1;
            return r;
        end
        if (e == '0)
        begin
            r.power_mod = 32'd1;
            return r;
        end
        m64 = {32'd0, m};
        acc = 64'd1 % m64;
        sq = {32'd0, b} % m64;
        n = e;
        while (n != '0)
        begin
            if (n[0])
            begin
                acc = (acc * sq) % m64;
            end
            sq = (sq * sq) % m64;
            n = n >> 1;
        end
        r.power_mod = acc[WIDTH-1:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase || r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 120);
    endfunction

    function automatic word_t pick_modulus(input int ph);
        case (ph % 8)
            0: return word_t'($urandom) | 32'd1;
            1: return '0;
            2: return word_t'($urandom_range(2, 255));
            3: return 32'd1;
            4: return '1;
            5: return word_t'($urandom) >> $urandom_range(0, 24);
            6: return {1'b1, 31'($urandom)};
            default: return ($urandom_range(0, 1) == 0) ? 32'h80000000 : 32'd2;
        endcase
    endfunction

    function automatic word_t random_base();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            return word_t'($urandom);
        end
        if (r == 6)
        begin
            return word_t'($urandom_range(0, 15));
        end
        if (r == 7)
        begin
            return modulus_setting + word_t'($urandom_range(0, 3));
        end
        if (r == 8)
        begin
            return '0;
        end
        return '1;
    endfunction

    function automatic word_t random_exponent();
        int w;
        w = ($urandom_range(0, 2) == 0) ? 32 : $urandom_range(0, 16);
        if (w == 32)
        begin
            return word_t'($urandom);
        end
        return word_t'($urandom) & ((32'd1 << w) - 32'd1);
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endtask

    task automatic send_word(input word_t b, input word_t e, input logic typed,
                             input power_result_t typed_result);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.base <= b;
        req_if.exponent <= e;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
        if (typed)
        begin
            pending_results.push_back(typed_result);
        end
        else
        begin
            pending_results.push_back(predict_power(b, e, modulus_setting));
        end
        words_sent++;
    endtask

    task automatic write_modulus(input word_t value);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        modulus_setting = value;
        moduli_written++;
    endtask

    task automatic check_result(input word_t got_pow, input logic got_err);
        power_result_t want;
        if (pending_results.size() == 0)
        begin
            note_failure($sformatf("unexpected result: power_mod %h modulus_error %b",
                                   got_pow, got_err));
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (got_err)
        begin
            error_results++;
        end
        if (want.power_mod !== got_pow || want.modulus_error !== got_err)
        begin
            note_failure($sformatf(
                "mismatch on result %0d: power_mod exp %h got %h, modulus_error exp %b got %b",
                results_checked, want.power_mod, got_pow, want.modulus_error, got_err));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("timeout with %0d results still expected", pending_results.size());
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            int stall;
            stall = pick_gap();
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            check_result(rsp_if.power_mod, rsp_if.modulus_error);
        end
    end

    initial
    begin
        power_result_t typed_result;
        int            drain_cycles;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        req_if.valid <= 1'b0;
        req_if.base <= '0;
        req_if.exponent <= '0;
        modulus_setting = 32'd1;
        calm_phase = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].load_modulus)
            begin
                write_modulus(directed_rows[i].modulus);
            end
            typed_result.power_mod = directed_rows[i].power_mod;
            typed_result.modulus_error = directed_rows[i].modulus_error;
            send_word(directed_rows[i].base, directed_rows[i].exponent,
                      directed_rows[i].typed, typed_result);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            calm_phase = (ph % 4 == 3);
            write_modulus(pick_modulus(ph));
            for (int k = 0; k < WORDS_PER_PHASE; k++)
            begin
                send_word(random_base(), random_exponent(), 1'b0, '0);
            end
        end

        req_if.valid <= 1'b0;
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        if (pending_results.size() != 0)
        begin
            note_failure($sformatf("%0d expected results never arrived",
                                   pending_results.size()));
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d words under %0d modulus settings and checked %0d results.",
                 words_sent, moduli_written, results_checked);
        $display("%0d results carried the modulus error flag; %0d failures were counted.",
                 error_results, failures);
        if (failures == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
